@@ hdl/cmap_pkg.sv @@
package cmap_pkg;

	localparam int unsigned HW_WIDTH = 8;

	typedef struct packed {
		logic signed [31:0] eps_sample;
		logic signed [31:0] y_sample;
		logic               last_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] eps_average;
		logic signed [31:0] y_average;
		logic               last_average;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch input, start memory read
		logic update;     // update sums, write memory
		logic div_start;  // launch divider
		logic clear;      // drop series state, load half_window
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic emit;       // this item produces a result
		logic div_done;
	} dp_sts_t;

endpackage

@@ hdl/cmap_ctrl.sv @@
module cmap_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              cfg_we,
	input  cmap_pkg::dp_sts_t sts,
	output cmap_pkg::dp_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_UPD  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd.clear = cfg_we;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_UPD;
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (!sts.emit) begin
					state_d = ST_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = sts.div_done;
				if (sts.div_done && out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept while result pending");
	a_upd_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> $past(state_q == ST_READ)) else $error("update out of order");
`endif

endmodule

@@ hdl/cmap_div.sv @@
// Restoring signed divide of a 41-bit sum by a 10-bit length (9 bits in cmap_dp), one bit a cycle.
module cmap_div #(
	parameter int unsigned NUM_W = 41,
	parameter int unsigned DEN_W = 10,
	parameter int unsigned Q_W   = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic        [DEN_W-1:0] den,
	output logic                    done,
	output logic signed [Q_W-1:0]   quo
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   shifted;
	logic [NUM_W-1:0] neg_res;

	assign shifted = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign neg_res = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quo     = Q_W'(neg_res);
	assign done    = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num[NUM_W-1] ? (~num + 1'b1) : num;
			neg_q <= num[NUM_W-1];
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DEN_W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

endmodule

@@ hdl/cmap_dp.sv @@
module cmap_dp #(
	parameter int unsigned MAX_HALF_WINDOW = 255
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cmap_pkg::dp_cmd_t                   cmd,
	output cmap_pkg::dp_sts_t                   sts,
	input  logic [cmap_pkg::HW_WIDTH-1:0]       cfg_data,
	input  cmap_pkg::in_item_t                  in_item,
	output cmap_pkg::out_item_t                 out_item
);

	localparam int unsigned DEPTH = 2 * MAX_HALF_WINDOW + 1;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned LW    = $clog2(DEPTH + 1);
	// sample width plus room for a full window of samples
	localparam int unsigned SW    = 32 + AW;

	logic [cmap_pkg::HW_WIDTH-1:0] hw_q;
	logic [LW-1:0]     len;
	logic [LW-1:0]     fill_q;
	logic [AW-1:0]     wr_q;
	logic [AW-1:0]     rd_addr;
	logic [AW:0]       rd_tmp;
	logic signed [SW-1:0] esum_q, ysum_q;
	logic [31:0]       emem [DEPTH];
	logic [31:0]       ymem [DEPTH];
	logic [31:0]       eold_q, yold_q;
	cmap_pkg::in_item_t item_q;
	logic              emit_q;
	logic              full;
	logic              edone, ydone;
	logic signed [31:0] eq, yq;

	always_comb begin
		if (32'(hw_q) > MAX_HALF_WINDOW) begin
			len = LW'(DEPTH);
		end else begin
			len = LW'({hw_q, 1'b1});
		end
	end

	assign full = fill_q >= len;
	// oldest slot: wr - len modulo depth
	assign rd_tmp  = {1'b0, wr_q} + (AW+1)'(DEPTH) - (AW+1)'(len);
	assign rd_addr = (rd_tmp >= (AW+1)'(DEPTH)) ? AW'(rd_tmp - (AW+1)'(DEPTH)) : AW'(rd_tmp);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
			eold_q <= emem[rd_addr];
			yold_q <= ymem[rd_addr];
		end
		if (cmd.update) begin
			emem[wr_q] <= item_q.eps_sample;
			ymem[wr_q] <= item_q.y_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q   <= '0;
			fill_q <= '0;
			wr_q   <= '0;
			esum_q <= '0;
			ysum_q <= '0;
			emit_q <= 1'b0;
		end else if (cmd.clear) begin
			hw_q   <= cfg_data;
			fill_q <= '0;
			esum_q <= '0;
			ysum_q <= '0;
		end else if (cmd.update) begin
			wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (item_q.last_sample) begin
				fill_q <= '0;
				esum_q <= '0;
				ysum_q <= '0;
			end else begin
				esum_q <= esum_q + SW'(item_q.eps_sample)
					- (full ? SW'($signed(eold_q)) : SW'(0));
				ysum_q <= ysum_q + SW'(item_q.y_sample)
					- (full ? SW'($signed(yold_q)) : SW'(0));
				if (!full) fill_q <= fill_q + 1'b1;
			end
			emit_q <= full || (fill_q + 1'b1 >= len);
		end
	end

	// sums used for the divide are captured before the last-sample clear
	logic signed [SW-1:0] ediv_q, ydiv_q;
	logic [LW-1:0]        lendiv_q;
	logic                 last_q;
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			ediv_q <= esum_q + SW'(item_q.eps_sample)
				- (full ? SW'($signed(eold_q)) : SW'(0));
			ydiv_q <= ysum_q + SW'(item_q.y_sample)
				- (full ? SW'($signed(yold_q)) : SW'(0));
			lendiv_q <= len;
			last_q   <= item_q.last_sample;
		end
	end

	cmap_div #(.NUM_W(SW), .DEN_W(LW), .Q_W(32)) u_ediv (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(ediv_q), .den(lendiv_q), .done(edone), .quo(eq)
	);
	cmap_div #(.NUM_W(SW), .DEN_W(LW), .Q_W(32)) u_ydiv (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(ydiv_q), .den(lendiv_q), .done(ydone), .quo(yq)
	);

	assign sts.emit     = emit_q;
	assign sts.div_done = edone && ydone;
	assign out_item.eps_average  = eq;
	assign out_item.y_average    = yq;
	assign out_item.last_average = last_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n) fill_q <= len)
		else $error("fill count past window");
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q < AW'(DEPTH)) else $error("write pointer out of range");
	a_div_pair: assert property (@(posedge clk) disable iff (!arst_n) edone == ydone)
		else $error("dividers out of step");
`endif

endmodule

@@ hdl/centered_moving_average_pair.sv @@
// channel  | valid      | ready      | payload
// in       | in_valid   | in_ready   | in_item  (cmap_pkg::in_item_t)
// out      | out_valid  | out_ready  | out_item (cmap_pkg::out_item_t)
// cfg      | cfg_we     | -          | cfg_data (half_window)
// A sample steps through the idle, read, update and divide-decision states; with no
// result due it returns to idle, else the bit-serial divide starts (two dividers in
// step, one quotient bit a cycle). Delay-line memory: read on capture, write on update.
// Reset clears sums, fill count, write pointer and half_window; memory is not cleared.
// A stalled result holds the block until transferred.
module centered_moving_average_pair #(
	parameter int unsigned MAX_HALF_WINDOW = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cmap_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output cmap_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_data
);

	cmap_pkg::dp_cmd_t cmd;
	cmap_pkg::dp_sts_t sts;

	cmap_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cfg_we(cfg_we),
		.sts(sts), .cmd(cmd)
	);

	cmap_dp #(.MAX_HALF_WINDOW(MAX_HALF_WINDOW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .cfg_data(cfg_data),
		.in_item(in_item), .out_item(out_item)
	);

endmodule
